// ===== rtl/core/hbcd_pkg.sv =====
// Shared constants, types and helpers for the HTTP body chunked decoder.
package hbcd_pkg;

  // Width of the chunk-size and payload counters.
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned RECV_BITS  = 32;
  localparam int unsigned LEN_BITS   = 32;
  localparam int unsigned CMP_BITS   = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  localparam int unsigned EXT_BITS   = (COUNT_BITS > RECV_BITS) ? COUNT_BITS : RECV_BITS + 1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  localparam logic MODE_LENGTH  = 1'b0;
  localparam logic MODE_CHUNKED = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic                 data_valid;
    logic [7:0]           data_byte;
    logic                 body_done;
    logic                 format_error;
    logic [RECV_BITS-1:0] received_bytes;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // ASCII hex digit decode, either case.
  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/core/http_body_chunked_decoder.sv =====
// HTTP/1.1 message body decoder: length-delimited and chunked transfer coding.
// One result per input transaction, registered in the result register or skid entry.
// Throughput: one byte per clock while the skid is empty; all decode logic sits
//   between the state registers and a two-entry output buffer (result register
//   plus skid). The skid entry lets the input accept one more transaction on stall.
// Reset (rst_ni low, async): phase idle, counters and error cleared, buffer empty.
module http_body_chunked_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic                        body_mode_i,
  input  logic [hbcd_pkg::LEN_BITS-1:0] content_length_i,
  input  logic [7:0]                  byte_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        data_valid_o,
  output logic [7:0]                  data_byte_o,
  output logic                        body_done_o,
  output logic                        format_error_o,
  output logic [hbcd_pkg::RECV_BITS-1:0] received_bytes_o
);
  import hbcd_pkg::*;

  // Decoder phases. SIZE_LF waits for LF after CR on a size line,
  // DATA_CR / DATA_LF check the CRLF that closes chunk data.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEN,
    PH_HEX,
    PH_EXT,
    PH_SIZE_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_DONE
  } phase_e;

  phase_e               phase_q, phase_d;
  count_t               chunk_q, chunk_d;
  count_t               count_q, count_d;
  logic [LEN_BITS-1:0]  limit_q, limit_d;
  logic                 err_q, err_d;

  logic                 accept;
  logic                 drain;
  logic                 out_vld_q, skid_vld_q;
  result_t              res_d, out_q, skid_q;

  count_t               count_inc;
  hex_t                 hex;
  logic [EXT_BITS-1:0]  count_ext;

  assign in_ready_o = ~skid_vld_q;
  assign accept     = in_valid_i & in_ready_o;
  assign drain      = ~out_vld_q | out_ready_i;

  // Saturating payload counter increment.
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  assign hex       = hex_digit(byte_value_i);

  // Next state and result for the transaction at the input.
  always_comb begin
    phase_d = phase_q;
    chunk_d = chunk_q;
    count_d = count_q;
    limit_d = limit_q;
    err_d   = err_q;
    res_d   = '0;

    if (action_i == ACT_START) begin
      // A start aborts whatever body was in progress.
      count_d = '0;
      chunk_d = '0;
      err_d   = 1'b0;
      limit_d = content_length_i;
      if (body_mode_i == MODE_CHUNKED) begin
        phase_d = PH_HEX;
      end else begin
        phase_d = (content_length_i == '0) ? PH_DONE : PH_LEN;
      end
    end else begin
      unique case (phase_q)
        PH_LEN: begin
          res_d.data_valid = 1'b1;
          count_d          = count_inc;
          if (CMP_BITS'(count_inc) >= CMP_BITS'(limit_q)) begin
            phase_d = PH_DONE;
          end
        end
        PH_HEX: begin
          if (hex.ok) begin
            // Another digit would push the size past the counter width.
            if (|chunk_q[COUNT_BITS-1 -: 4]) begin
              err_d   = 1'b1;
              phase_d = PH_DONE;
            end else begin
              chunk_d = {chunk_q[COUNT_BITS-5:0], hex.value};
            end
          end else if (byte_value_i == CH_CR) begin
            phase_d = PH_SIZE_LF;
          end else begin
            phase_d = PH_EXT;
          end
        end
        PH_EXT: begin
          if (byte_value_i == CH_CR) begin
            phase_d = PH_SIZE_LF;
          end
        end
        PH_SIZE_LF: begin
          // A bare CR keeps waiting; anything else falls back to the extension.
          if (byte_value_i == CH_LF) begin
            phase_d = (chunk_q == '0) ? PH_DONE : PH_DATA;
          end else if (byte_value_i != CH_CR) begin
            phase_d = PH_EXT;
          end
        end
        PH_DATA: begin
          res_d.data_valid = 1'b1;
          count_d          = count_inc;
          if (chunk_q != '0) begin
            chunk_d = chunk_q - 1'b1;
          end
          if (chunk_q <= count_t'(1)) begin
            phase_d = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (byte_value_i == CH_CR) begin
            phase_d = PH_DATA_LF;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_DATA_LF: begin
          if (byte_value_i == CH_LF) begin
            chunk_d = '0;
            phase_d = PH_HEX;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        default: ;  // idle and done ignore bytes
      endcase
    end

    count_ext            = EXT_BITS'(count_d);
    res_d.data_byte      = res_d.data_valid ? byte_value_i : 8'h00;
    res_d.body_done      = (phase_d == PH_DONE);
    res_d.format_error   = err_d;
    res_d.received_bytes = (|count_ext[EXT_BITS-1:RECV_BITS]) ? '1
                                                              : count_ext[RECV_BITS-1:0];
  end

  // Decoder state and output buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      chunk_q    <= '0;
      count_q    <= '0;
      limit_q    <= '0;
      err_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        chunk_q <= chunk_d;
        count_q <= count_d;
        limit_q <= limit_d;
        err_q   <= err_d;
      end
      if (drain) begin
        out_vld_q  <= skid_vld_q | accept;
        skid_vld_q <= 1'b0;
      end else if (accept) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  // Result payload: skid entry always goes out ahead of a newer result.
  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign data_valid_o     = out_q.data_valid;
  assign data_byte_o      = out_q.data_byte;
  assign body_done_o      = out_q.body_done;
  assign format_error_o   = out_q.format_error;
  assign received_bytes_o = out_q.received_bytes;

endmodule

// ===== rtl/core/hbcd_checker.sv =====
// Port-level checks for the HTTP body chunked decoder, bound to the top level.
module hbcd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          data_valid_o,
  input logic [7:0]                    data_byte_o,
  input logic                          body_done_o,
  input logic                          format_error_o,
  input logic [hbcd_pkg::RECV_BITS-1:0] received_bytes_o
);
  import hbcd_pkg::*;

  // Stalled output transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_valid_o)
      && $stable(data_byte_o) && $stable(body_done_o) && $stable(format_error_o)
      && $stable(received_bytes_o))
    else $error("output transaction changed while stalled");

  // An error always ends the body.
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && format_error_o |-> body_done_o)
    else $error("format error without body done");

  // A payload byte is counted in the same result.
  a_data_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_valid_o |-> received_bytes_o != '0)
    else $error("payload byte with zero received count");

  // With the output empty the buffer has room.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind http_body_chunked_decoder hbcd_checker u_hbcd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .data_valid_o     (data_valid_o),
  .data_byte_o      (data_byte_o),
  .body_done_o      (body_done_o),
  .format_error_o   (format_error_o),
  .received_bytes_o (received_bytes_o)
);
